>>> hdl/atr_pkg.sv
// ----------------------------------------------------------------------------
// atr_pkg: shared types and constants for the ATR parser
// Control/status structs, byte class codes and the TA1 Fi/Di tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atr_pkg;

  // Byte classes reported on each result word
  localparam logic [3:0] KIND_TS   = 4'd0;
  localparam logic [3:0] KIND_T0   = 4'd1;
  localparam logic [3:0] KIND_TA   = 4'd2;
  localparam logic [3:0] KIND_TB   = 4'd3;
  localparam logic [3:0] KIND_TC   = 4'd4;
  localparam logic [3:0] KIND_TD   = 4'd5;
  localparam logic [3:0] KIND_HIST = 4'd6;
  localparam logic [3:0] KIND_TCK  = 4'd7;
  localparam logic [3:0] KIND_IGN  = 4'd8;

  // Parse status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_TS    = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  // Checksum state
  localparam logic [1:0] CK_NONE     = 2'd0;
  localparam logic [1:0] CK_MATCH    = 2'd1;
  localparam logic [1:0] CK_MISMATCH = 2'd2;
  localparam logic [1:0] CK_MISSING  = 2'd3;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  localparam logic [4:0] PROTO_NONE = 5'd16;

  // Baud numerator and divider geometry
  localparam logic [21:0] BAUD_NUM  = 22'd3750000;
  localparam int          DVD_W     = 28;  // 3750000 * 64 < 2**28
  localparam int          DIV_STEPS = DVD_W;
  localparam int          FI_W      = 12;
  localparam int          DI_W      = 7;
  localparam int          BAUD_W    = 20;

  typedef struct packed {
    logic step;       // input word accepted this edge
    logic div_start;  // launch baud division
    logic emit;       // load result register
  } atr_cmd_t;

  typedef struct packed {
    logic div_req;    // TA1 decoded, baud must be computed
    logic div_done;   // quotient valid this cycle
  } atr_sts_t;

  function automatic logic [FI_W-1:0] fi_lookup(input logic [3:0] code);
    logic [FI_W-1:0] f;
    unique case (code)
      4'd0, 4'd1: f = 12'd372;
      4'd2:       f = 12'd558;
      4'd3:       f = 12'd744;
      4'd4:       f = 12'd1116;
      4'd5:       f = 12'd1488;
      4'd6:       f = 12'd1860;
      4'd9:       f = 12'd512;
      4'd10:      f = 12'd768;
      4'd11:      f = 12'd1024;
      4'd12:      f = 12'd1536;
      4'd13:      f = 12'd2048;
      default:    f = 12'd0;
    endcase
    return f;
  endfunction

  function automatic logic [DI_W-1:0] di_lookup(input logic [3:0] code);
    logic [DI_W-1:0] d;
    unique case (code)
      4'd1:    d = 7'd1;
      4'd2:    d = 7'd2;
      4'd3:    d = 7'd4;
      4'd4:    d = 7'd8;
      4'd5:    d = 7'd16;
      4'd6:    d = 7'd32;
      4'd7:    d = 7'd64;
      4'd8:    d = 7'd12;
      4'd9:    d = 7'd20;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hdl/atr_div.sv
// ----------------------------------------------------------------------------
// atr_div: restoring divider for the baud rate
// One quotient bit per cycle; dividend and quotient share a shift register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atr_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [atr_pkg::DVD_W-1:0]    dividend,
  input  wire logic [atr_pkg::FI_W-1:0]     divisor,
  output logic                              done,
  output logic [atr_pkg::BAUD_W-1:0]        quotient
);
  import atr_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [FI_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [FI_W:0]    trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? FI_W'(trial - {1'b0, divisor}) : trial[FI_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = quo_nxt[BAUD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

>>> hdl/atr_ctrl.sv
// ----------------------------------------------------------------------------
// atr_ctrl: sequencer for the ATR parser
// Accepts a word, optionally runs the baud division, then loads the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output atr_pkg::atr_cmd_t      cmd,
  input  wire atr_pkg::atr_sts_t sts
);
  import atr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_OUT} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    out_free      = !out_valid_r || out_ready;
    cmd.step      = in_valid && in_ready;
    cmd.div_start = (state_r == S_CHECK) && sts.div_req;
    cmd.emit      = (state_r == S_OUT) && out_free;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:  if (cmd.step) state_r <= S_CHECK;
        S_CHECK: state_r <= sts.div_req ? S_DIV : S_OUT;
        S_DIV:   if (sts.div_done) state_r <= S_OUT;
        S_OUT:   if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_emit_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !$past(cmd.step))
    else $error("result loaded in the cycle right after accept");

endmodule

`default_nettype wire

>>> hdl/atr_dp.sv
// ----------------------------------------------------------------------------
// atr_dp: ATR parse datapath
// Parse state, byte classification, baud divider and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire atr_pkg::atr_cmd_t           cmd,
  output atr_pkg::atr_sts_t                sts,
  input  wire logic [7:0]                  in_atr_byte,
  input  wire logic                        in_is_last,
  output logic [3:0]                       out_byte_kind,
  output logic                             out_done_res,
  output logic [1:0]                       out_status,
  output logic [atr_pkg::FI_W-1:0]         out_clock_rate_factor,
  output logic [atr_pkg::DI_W-1:0]         out_bit_rate_factor,
  output logic [atr_pkg::BAUD_W-1:0]       out_baud_rate,
  output logic [7:0]                       out_guard_time,
  output logic [7:0]                       out_waiting_time,
  output logic [2:0]                       out_prog_voltage,
  output logic [4:0]                       out_prog_current,
  output logic [15:0]                      out_protocol_mask,
  output logic [1:0]                       out_checksum_state
);
  import atr_pkg::*;

  typedef enum logic [2:0] {
    PH_TS, PH_T0, PH_IFACE, PH_HIST, PH_TCK, PH_TRAIL, PH_FAILED
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        pend_r, pend_nxt;
  logic              grp_started_r, grp_started_nxt;
  logic [3:0]        grp_num_r, grp_num_nxt;
  logic [3:0]        hist_r, hist_nxt;
  logic [1:0]        pstat_r, pstat_nxt;
  logic [FI_W-1:0]   fi_r, fi_nxt;
  logic [DI_W-1:0]   di_r, di_nxt;
  logic [BAUD_W-1:0] baud_r;
  logic [7:0]        guard_r, guard_nxt;
  logic [7:0]        wait_r, wait_nxt;
  logic [7:0]        tb1_r, tb1_nxt;
  logic [15:0]       protos_r, protos_nxt;
  logic [4:0]        first_r, first_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [1:0]        tck_r, tck_nxt;
  logic              div_req_r, div_req_nxt;
  logic [3:0]        kind_r, kind_nxt;
  logic              last_r;
  logic              clear;

  logic [DVD_W-1:0]  dividend;
  logic              div_done;
  logic [BAUD_W-1:0] quotient;
  logic [3:0]        proto;

  logic [1:0]        fin_status;
  logic [1:0]        fin_ck;
  logic              fin_report;

  function automatic phase_t after_hist(input logic [4:0] fp);
    return ((fp != PROTO_NONE) && (fp != 5'd0)) ? PH_TCK : PH_TRAIL;
  endfunction

  // Per-byte parse step
  always_comb begin
    phase_nxt       = phase_r;
    pend_nxt        = pend_r;
    grp_started_nxt = grp_started_r;
    grp_num_nxt     = grp_num_r;
    hist_nxt        = hist_r;
    pstat_nxt       = pstat_r;
    fi_nxt          = fi_r;
    di_nxt          = di_r;
    guard_nxt       = guard_r;
    wait_nxt        = wait_r;
    tb1_nxt         = tb1_r;
    protos_nxt      = protos_r;
    first_nxt       = first_r;
    xor_nxt         = xor_r;
    tck_nxt         = tck_r;
    div_req_nxt     = 1'b0;
    kind_nxt        = KIND_IGN;
    proto           = in_atr_byte[3:0];

    unique case (phase_r)
      PH_TS: begin
        kind_nxt = KIND_TS;
        if (in_atr_byte == TS_DIRECT || in_atr_byte == TS_INVERSE) begin
          phase_nxt = PH_T0;
        end else begin
          pstat_nxt = ST_BAD_TS;
          phase_nxt = PH_FAILED;
        end
        if (in_is_last) pstat_nxt = ST_SHORT;
      end
      PH_T0: begin
        kind_nxt        = KIND_T0;
        xor_nxt         = xor_r ^ in_atr_byte;
        hist_nxt        = in_atr_byte[3:0];
        pend_nxt        = in_atr_byte[7:4];
        grp_started_nxt = 1'b0;
        if (pend_nxt != 4'd0) phase_nxt = PH_IFACE;
        else if (hist_nxt != 4'd0) phase_nxt = PH_HIST;
        else phase_nxt = after_hist(first_r);
      end
      PH_IFACE: begin
        xor_nxt = xor_r ^ in_atr_byte;
        if (pend_r[0]) begin
          kind_nxt        = KIND_TA;
          pend_nxt        = pend_r & 4'hE;
          grp_started_nxt = 1'b1;
          if (grp_num_r == 4'd1) begin
            fi_nxt      = fi_lookup(in_atr_byte[7:4]);
            di_nxt      = di_lookup(in_atr_byte[3:0]);
            div_req_nxt = (fi_nxt != '0) && (di_nxt != '0);
          end
        end else if (pend_r[1]) begin
          kind_nxt        = KIND_TB;
          pend_nxt        = pend_r & 4'hC;
          grp_started_nxt = 1'b1;
          if (grp_num_r == 4'd1) tb1_nxt = in_atr_byte;
        end else if (pend_r[2]) begin
          kind_nxt        = KIND_TC;
          pend_nxt        = pend_r & 4'h8;
          grp_started_nxt = 1'b1;
          if (grp_num_r == 4'd1) guard_nxt = in_atr_byte;
          else if (grp_num_r == 4'd2) wait_nxt = in_atr_byte;
        end else begin
          kind_nxt   = KIND_TD;
          protos_nxt = protos_r | (16'd1 << proto);
          if (first_r == PROTO_NONE) first_nxt = {1'b0, proto};
          if (grp_num_r != 4'd15) grp_num_nxt = grp_num_r + 4'd1;
          pend_nxt        = in_atr_byte[7:4];
          grp_started_nxt = 1'b0;
        end
        if (pend_nxt == 4'd0) begin
          if (hist_r != 4'd0) phase_nxt = PH_HIST;
          else phase_nxt = after_hist(first_nxt);
        end
      end
      PH_HIST: begin
        kind_nxt = KIND_HIST;
        xor_nxt  = xor_r ^ in_atr_byte;
        hist_nxt = hist_r - 4'd1;
        if (hist_nxt == 4'd0) phase_nxt = after_hist(first_r);
      end
      PH_TCK: begin
        kind_nxt  = KIND_TCK;
        tck_nxt   = (in_atr_byte == xor_r) ? CK_MATCH : CK_MISMATCH;
        phase_nxt = PH_TRAIL;
      end
      default: kind_nxt = KIND_IGN;
    endcase
  end

  // Summary as reported on the last byte
  always_comb begin
    fin_status = pstat_r;
    if (pstat_r == ST_OK && phase_r == PH_IFACE && grp_started_r && pend_r != 4'd0)
      fin_status = ST_TRUNCATED;
    if ((first_r == PROTO_NONE) || (first_r == 5'd0)) fin_ck = CK_NONE;
    else if (tck_r == CK_NONE) fin_ck = CK_MISSING;
    else fin_ck = tck_r;
  end

  assign fin_report   = last_r && (fin_status == ST_OK);
  assign dividend     = DVD_W'(BAUD_NUM) * DVD_W'(di_r);
  assign clear        = cmd.emit && last_r;
  assign sts.div_req  = div_req_r;
  assign sts.div_done = div_done;

  atr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (fi_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r       <= PH_TS;
      pend_r        <= '0;
      grp_started_r <= 1'b0;
      grp_num_r     <= 4'd1;
      hist_r        <= '0;
      pstat_r       <= ST_OK;
      fi_r          <= '0;
      di_r          <= '0;
      baud_r        <= '0;
      guard_r       <= '0;
      wait_r        <= '0;
      tb1_r         <= '0;
      protos_r      <= '0;
      first_r       <= PROTO_NONE;
      xor_r         <= '0;
      tck_r         <= CK_NONE;
      div_req_r     <= 1'b0;
    end else begin
      if (cmd.step) begin
        phase_r       <= phase_nxt;
        pend_r        <= pend_nxt;
        grp_started_r <= grp_started_nxt;
        grp_num_r     <= grp_num_nxt;
        hist_r        <= hist_nxt;
        pstat_r       <= pstat_nxt;
        fi_r          <= fi_nxt;
        di_r          <= di_nxt;
        guard_r       <= guard_nxt;
        wait_r        <= wait_nxt;
        tb1_r         <= tb1_nxt;
        protos_r      <= protos_nxt;
        first_r       <= first_nxt;
        xor_r         <= xor_nxt;
        tck_r         <= tck_nxt;
        div_req_r     <= div_req_nxt;
      end else if (cmd.div_start) begin
        div_req_r <= 1'b0;
      end
      if (div_done) baud_r <= quotient;
    end
  end

  // Word context and result register; summary fields only on a clean last word
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      kind_r <= kind_nxt;
      last_r <= in_is_last;
    end
    if (cmd.emit) begin
      out_byte_kind         <= kind_r;
      out_done_res          <= last_r;
      out_status            <= last_r ? fin_status : ST_OK;
      out_clock_rate_factor <= fin_report ? fi_r : '0;
      out_bit_rate_factor   <= fin_report ? di_r : '0;
      out_baud_rate         <= fin_report ? baud_r : '0;
      out_guard_time        <= fin_report ? guard_r : '0;
      out_waiting_time      <= fin_report ? wait_r : '0;
      out_prog_voltage      <= fin_report ? tb1_r[7:5] : '0;
      out_prog_current      <= fin_report ? tb1_r[4:0] : '0;
      out_protocol_mask     <= fin_report ? protos_r : '0;
      out_checksum_state    <= fin_report ? fin_ck : CK_NONE;
    end
  end

  a_baud_needs_ta1: assert property (@(posedge clk) disable iff (!rst_n)
    (baud_r != '0) |-> (fi_r != '0 && di_r != '0))
    else $error("baud set without a valid TA1");

endmodule

`default_nettype wire

>>> hdl/smartcard_atr_parser.sv
// ----------------------------------------------------------------------------
// smartcard_atr_parser: streaming ISO 7816-3 answer-to-reset parser
// Classifies each ATR byte and reports the decoded summary on the last byte.
// ----------------------------------------------------------------------------
//
//  channel  direction  ports
//  -------  ---------  -----------------------------------------------------
//  in       sink       in_valid/in_ready, in_atr_byte, in_is_last
//  out      source     out_valid/out_ready, out_byte_kind ... out_checksum_state
//
//  One word is processed at a time; each accepted word yields one result word.
//  A word passes through the accept, check and load states; the result register
//  is loaded once it is free, and the next word can be taken after that.
//  A TA1 with known Fi and Di adds a divide state in which the restoring
//  divider forms baud = 3750000*Di/Fi before the result is loaded.
//  The result register lets the next word be accepted while a result waits.
//  Reset is synchronous, active low; after a last word the parse state returns
//  to reset so the next word is the TS of a new ATR.
//
`timescale 1ns / 1ps
`default_nettype none

module smartcard_atr_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_atr_byte,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_byte_kind,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic [11:0]      out_clock_rate_factor,
  output logic [6:0]       out_bit_rate_factor,
  output logic [19:0]      out_baud_rate,
  output logic [7:0]       out_guard_time,
  output logic [7:0]       out_waiting_time,
  output logic [2:0]       out_prog_voltage,
  output logic [4:0]       out_prog_current,
  output logic [15:0]      out_protocol_mask,
  output logic [1:0]       out_checksum_state
);
  import atr_pkg::*;

  // Commands from the sequencer, status back from the datapath
  atr_cmd_t cmd;
  atr_sts_t sts;

  atr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Parse state, TA1 tables, baud divider and the result register
  atr_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_atr_byte           (in_atr_byte),
    .in_is_last            (in_is_last),
    .out_byte_kind         (out_byte_kind),
    .out_done_res          (out_done_res),
    .out_status            (out_status),
    .out_clock_rate_factor (out_clock_rate_factor),
    .out_bit_rate_factor   (out_bit_rate_factor),
    .out_baud_rate         (out_baud_rate),
    .out_guard_time        (out_guard_time),
    .out_waiting_time      (out_waiting_time),
    .out_prog_voltage      (out_prog_voltage),
    .out_prog_current      (out_prog_current),
    .out_protocol_mask     (out_protocol_mask),
    .out_checksum_state    (out_checksum_state)
  );

endmodule

`default_nettype wire
